// ===== rtl/ec_point_add_and_scalar_multiply_defines.svh =====
// Assertion macros shared by the point arithmetic block
`ifndef EC_POINT_ADD_AND_SCALAR_MULTIPLY_DEFINES_SVH
`define EC_POINT_ADD_AND_SCALAR_MULTIPLY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition implies consequence in the same cycle
`define ECPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecpm check failed: same-cycle implication");
// Condition implies consequence in the next cycle
`define ECPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecpm check failed: next-cycle implication");
`else
`define ECPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ECPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ecpm_pkg.sv =====
// Shared types and constants of the point arithmetic block
`default_nettype none
package ecpm_pkg;

    // Configuration register indexes
    localparam logic [0:0] CFG_CURVE_A       = 1'b0;
    localparam logic [0:0] CFG_PRIME_MODULUS = 1'b1;

    // Request kinds
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_MUL = 1'b1;

    // Modulus after reset
    localparam int RESET_MODULUS = 65521;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_R_FROM_P1,
        OP_R_FROM_S,
        OP_S_FROM_R,
        OP_S_FROM_P1,
        OP_SET_INF,
        OP_NUM_DBL,
        OP_NUM_CHORD,
        OP_INV_INIT,
        OP_DIV,
        OP_EUC_STEP,
        OP_INV_FIN,
        OP_X3,
        OP_DIFF,
        OP_Y3,
        OP_KSHIFT
    } dp_op_t;

    // Operand sources of the modular multiplier
    typedef enum logic [3:0] {
        SRC_ONE,
        SRC_THREE,
        SRC_A,
        SRC_P1X,
        SRC_P1Y,
        SRC_SX,
        SRC_SY,
        SRC_RX,
        SRC_NUM,
        SRC_LAM,
        SRC_TMP
    } src_t;

    // Destinations of the modular multiplier
    typedef enum logic [2:0] {
        DST_A,
        DST_P1X,
        DST_P1Y,
        DST_SX,
        DST_SY,
        DST_TMP,
        DST_LAM
    } dst_t;

    typedef struct packed {
        dp_op_t op;
        src_t   usel;
        src_t   vsel;
        dst_t   dst;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic small_mod;
        logic req_mul;
        logic rinf;
        logic sinf;
        logic p1inf;
        logic xeq;
        logic yeq;
        logic yneg;
        logic r1zero;
        logic gcd_one;
        logic kbit;
        logic kzero;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/ecpm_ctrl.sv =====
// Sequencer of the point arithmetic block: request flow, point add, inverse loop, double-and-add
`default_nettype none
module ecpm_ctrl
    import ecpm_pkg::*;
#(
    parameter int SCALAR_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       out_free,
    output logic            out_load,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int BW = $clog2(SCALAR_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK_MOD,
        S_RED_A,
        S_RED_P1X,
        S_RED_P1Y,
        S_RED_SX,
        S_RED_SY,
        S_DISPATCH,
        S_MUL_WAIT,
        S_DIV_WAIT,
        S_PA_CHECK,
        S_PA_SQ,
        S_PA_TRIPLE,
        S_PA_NUMDBL,
        S_INV_INIT,
        S_INV_LOOP,
        S_INV_STEP,
        S_INV_FIN,
        S_PA_LAM,
        S_PA_LAMSQ,
        S_PA_X3,
        S_PA_DIFF,
        S_PA_YMUL,
        S_PA_Y3,
        S_SM_DBL,
        S_SM_ADD,
        S_SM_NEXT,
        S_DONE
    } state_t;

    localparam dp_cmd_t CMD_IDLE = '{op: OP_NONE, usel: SRC_ONE, vsel: SRC_ONE, dst: DST_TMP};

    state_t          state_reg, state_next;
    state_t          mret_reg, mret_next;
    state_t          pret_reg, pret_next;
    logic [BW-1:0]   bit_cnt_reg, bit_cnt_next;

    function automatic dp_cmd_t mul_cmd(input src_t u, input src_t v, input dst_t d);
        dp_cmd_t c;
        c = '{op: OP_MUL, usel: u, vsel: v, dst: d};
        return c;
    endfunction

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        mret_next    = mret_reg;
        pret_next    = pret_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd          = CMD_IDLE;
        in_ready     = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK_MOD;
                end
            end
            S_CHECK_MOD:
            begin
                if (status.small_mod)
                begin
                    cmd.op     = OP_SET_INF;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RED_A;
                end
            end
            S_RED_A:
            begin
                cmd        = mul_cmd(SRC_A, SRC_ONE, DST_A);
                mret_next  = S_RED_P1X;
                state_next = S_MUL_WAIT;
            end
            S_RED_P1X:
            begin
                cmd        = mul_cmd(SRC_P1X, SRC_ONE, DST_P1X);
                mret_next  = S_RED_P1Y;
                state_next = S_MUL_WAIT;
            end
            S_RED_P1Y:
            begin
                cmd        = mul_cmd(SRC_P1Y, SRC_ONE, DST_P1Y);
                mret_next  = S_RED_SX;
                state_next = S_MUL_WAIT;
            end
            S_RED_SX:
            begin
                cmd        = mul_cmd(SRC_SX, SRC_ONE, DST_SX);
                mret_next  = S_RED_SY;
                state_next = S_MUL_WAIT;
            end
            S_RED_SY:
            begin
                cmd        = mul_cmd(SRC_SY, SRC_ONE, DST_SY);
                mret_next  = S_DISPATCH;
                state_next = S_MUL_WAIT;
            end
            S_DISPATCH:
            begin
                if (status.req_mul)
                begin
                    cmd.op = OP_SET_INF;
                    if (status.kzero || status.p1inf)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bit_cnt_next = BW'(SCALAR_BITS);
                        state_next   = S_SM_DBL;
                    end
                end
                else
                begin
                    cmd.op     = OP_R_FROM_P1;
                    pret_next  = S_DONE;
                    state_next = S_PA_CHECK;
                end
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = mret_reg;
                end
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_INV_STEP;
                end
            end
            // Operand cases of the point addition
            S_PA_CHECK:
            begin
                if (status.rinf)
                begin
                    cmd.op     = OP_R_FROM_S;
                    state_next = pret_reg;
                end
                else if (status.sinf)
                begin
                    state_next = pret_reg;
                end
                else if (status.xeq && status.yneg)
                begin
                    cmd.op     = OP_SET_INF;
                    state_next = pret_reg;
                end
                else if (status.xeq && status.yeq)
                begin
                    state_next = S_PA_SQ;
                end
                else
                begin
                    cmd.op     = OP_NUM_CHORD;
                    state_next = S_INV_INIT;
                end
            end
            S_PA_SQ:
            begin
                cmd        = mul_cmd(SRC_RX, SRC_RX, DST_TMP);
                mret_next  = S_PA_TRIPLE;
                state_next = S_MUL_WAIT;
            end
            S_PA_TRIPLE:
            begin
                cmd        = mul_cmd(SRC_THREE, SRC_TMP, DST_TMP);
                mret_next  = S_PA_NUMDBL;
                state_next = S_MUL_WAIT;
            end
            S_PA_NUMDBL:
            begin
                cmd.op     = OP_NUM_DBL;
                state_next = S_INV_INIT;
            end
            // Extended Euclid on the slope denominator
            S_INV_INIT:
            begin
                cmd.op     = OP_INV_INIT;
                state_next = S_INV_LOOP;
            end
            S_INV_LOOP:
            begin
                if (status.r1zero)
                begin
                    state_next = S_INV_FIN;
                end
                else
                begin
                    cmd.op     = OP_DIV;
                    state_next = S_DIV_WAIT;
                end
            end
            S_INV_STEP:
            begin
                cmd.op     = OP_EUC_STEP;
                state_next = S_INV_LOOP;
            end
            S_INV_FIN:
            begin
                if (status.gcd_one)
                begin
                    cmd.op     = OP_INV_FIN;
                    state_next = S_PA_LAM;
                end
                else
                begin
                    cmd.op     = OP_SET_INF;
                    state_next = pret_reg;
                end
            end
            S_PA_LAM:
            begin
                cmd        = mul_cmd(SRC_NUM, SRC_TMP, DST_LAM);
                mret_next  = S_PA_LAMSQ;
                state_next = S_MUL_WAIT;
            end
            S_PA_LAMSQ:
            begin
                cmd        = mul_cmd(SRC_LAM, SRC_LAM, DST_TMP);
                mret_next  = S_PA_X3;
                state_next = S_MUL_WAIT;
            end
            S_PA_X3:
            begin
                cmd.op     = OP_X3;
                state_next = S_PA_DIFF;
            end
            S_PA_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_PA_YMUL;
            end
            S_PA_YMUL:
            begin
                cmd        = mul_cmd(SRC_LAM, SRC_TMP, DST_TMP);
                mret_next  = S_PA_Y3;
                state_next = S_MUL_WAIT;
            end
            S_PA_Y3:
            begin
                cmd.op     = OP_Y3;
                state_next = pret_reg;
            end
            // Double-and-add over the scalar, top bit first
            S_SM_DBL:
            begin
                cmd.op     = OP_S_FROM_R;
                pret_next  = S_SM_ADD;
                state_next = S_PA_CHECK;
            end
            S_SM_ADD:
            begin
                if (status.kbit)
                begin
                    cmd.op     = OP_S_FROM_P1;
                    pret_next  = S_SM_NEXT;
                    state_next = S_PA_CHECK;
                end
                else
                begin
                    state_next = S_SM_NEXT;
                end
            end
            S_SM_NEXT:
            begin
                cmd.op       = OP_KSHIFT;
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == BW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SM_DBL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and return points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mret_reg    <= S_IDLE;
            pret_reg    <= S_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mret_reg    <= mret_next;
            pret_reg    <= pret_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ecpm_datapath.sv =====
// Datapath: configuration, point registers, serial modular multiplier, divider, Euclid
`default_nettype none
module ecpm_datapath
    import ecpm_pkg::*;
#(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_addr,
    input  wire logic [FIELD_BITS-1:0]  cfg_wdata,
    input  wire logic                   req_type,
    input  wire logic [FIELD_BITS-1:0]  first_x,
    input  wire logic [FIELD_BITS-1:0]  first_y,
    input  wire logic                   first_inf,
    input  wire logic [FIELD_BITS-1:0]  second_x,
    input  wire logic [FIELD_BITS-1:0]  second_y,
    input  wire logic                   second_inf,
    input  wire logic [SCALAR_BITS-1:0] scalar,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    output logic [FIELD_BITS-1:0]       result_x,
    output logic [FIELD_BITS-1:0]       result_y,
    output logic                        result_inf
);

    localparam int F  = FIELD_BITS;
    localparam int S  = SCALAR_BITS;
    localparam int CW = $clog2(F + 1);
    localparam int TW = F + 2;
    localparam int PW = 2 * F + 3;
    localparam logic [F-1:0] M_RST = F'(RESET_MODULUS);

    // Configuration
    logic [F-1:0] a_cfg_reg;
    logic [F-1:0] m_reg;

    // Point and work registers
    logic [F-1:0] a_reg, p1x_reg, p1y_reg, sx_reg, sy_reg, rx_reg, ry_reg;
    logic         p1inf_reg, sinf_reg, rinf_reg, req_reg;
    logic [S-1:0] k_reg;
    logic [F-1:0] num_reg, den_reg, lam_reg, tmp_reg, x3_reg;

    // Multiplier
    logic [F-1:0]  mul_u_reg, mul_v_reg, mul_acc_reg;
    dst_t          mul_dst_reg;
    logic          mul_busy_reg;
    logic [CW-1:0] mul_cnt_reg;
    logic [F:0]    mul_dbl, mul_d1, mul_sum;
    logic [F-1:0]  mul_res, mul_u_src, mul_v_src;
    logic          mul_done;

    // Divider and Euclid
    logic [F-1:0]         r0_reg, r1_reg, div_q_reg, div_rem_reg;
    logic signed [TW-1:0] t0_reg, t1_reg;
    logic                 div_busy_reg;
    logic [CW-1:0]        div_cnt_reg;
    logic [F:0]           div_rr, div_sub;
    logic                 div_ge, div_done;
    logic [F-1:0]         div_rem_next, div_q_next;
    logic signed [PW-1:0] euc_qs, euc_t0s, euc_t1s, euc_prod, euc_tn;
    logic [TW-1:0]        inv_u, inv_a, inv_b;

    logic [F-1:0] x3_part, x3_next;

    function automatic logic [F-1:0] addm(input logic [F-1:0] x, input logic [F-1:0] y,
                                          input logic [F-1:0] mm);
        logic [F:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, mm})
        begin
            s = s - {1'b0, mm};
        end
        return s[F-1:0];
    endfunction

    function automatic logic [F-1:0] subm(input logic [F-1:0] x, input logic [F-1:0] y,
                                          input logic [F-1:0] mm);
        logic [F:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (d[F])
        begin
            d = d + {1'b0, mm};
        end
        return d[F-1:0];
    endfunction

    function automatic logic [F-1:0] pick(input src_t sel, input logic [F-1:0] a_cfg,
                                          input logic [F-1:0] p1x, input logic [F-1:0] p1y,
                                          input logic [F-1:0] sx, input logic [F-1:0] sy,
                                          input logic [F-1:0] rx, input logic [F-1:0] num,
                                          input logic [F-1:0] lam, input logic [F-1:0] tmp);
        logic [F-1:0] v;
        case (sel)
            SRC_ONE:   v = F'(1);
            SRC_THREE: v = F'(3);
            SRC_A:     v = a_cfg;
            SRC_P1X:   v = p1x;
            SRC_P1Y:   v = p1y;
            SRC_SX:    v = sx;
            SRC_SY:    v = sy;
            SRC_RX:    v = rx;
            SRC_NUM:   v = num;
            SRC_LAM:   v = lam;
            SRC_TMP:   v = tmp;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // Select multiplier operands
    assign mul_u_src = pick(cmd.usel, a_cfg_reg, p1x_reg, p1y_reg, sx_reg, sy_reg, rx_reg,
                            num_reg, lam_reg, tmp_reg);
    assign mul_v_src = pick(cmd.vsel, a_cfg_reg, p1x_reg, p1y_reg, sx_reg, sy_reg, rx_reg,
                            num_reg, lam_reg, tmp_reg);

    // One multiplier bit per cycle: acc = 2*acc + bit*v, kept below m
    always_comb
    begin
        mul_dbl = {mul_acc_reg, 1'b0};
        mul_d1  = (mul_dbl >= {1'b0, m_reg}) ? mul_dbl - {1'b0, m_reg} : mul_dbl;
        mul_sum = mul_d1 + (mul_u_reg[F-1] ? {1'b0, mul_v_reg} : '0);
        mul_res = (mul_sum >= {1'b0, m_reg}) ? F'(mul_sum - {1'b0, m_reg}) : mul_sum[F-1:0];
    end
    assign mul_done = mul_busy_reg && (mul_cnt_reg == CW'(1));

    // One quotient bit per cycle of r0 / r1
    always_comb
    begin
        div_rr       = {div_rem_reg, div_q_reg[F-1]};
        div_sub      = div_rr - {1'b0, r1_reg};
        div_ge       = (div_rr >= {1'b0, r1_reg});
        div_rem_next = div_ge ? div_sub[F-1:0] : div_rr[F-1:0];
        div_q_next   = {div_q_reg[F-2:0], div_ge};
    end
    assign div_done = div_busy_reg && (div_cnt_reg == CW'(1));

    // Euclid cofactor update and final normalization
    always_comb
    begin
        euc_qs   = {{(PW - F){1'b0}}, div_q_reg};
        euc_t0s  = {{(PW - TW){t0_reg[TW-1]}}, t0_reg};
        euc_t1s  = {{(PW - TW){t1_reg[TW-1]}}, t1_reg};
        euc_prod = euc_qs * euc_t1s;
        euc_tn   = euc_t0s - euc_prod;
        inv_u    = t0_reg;
        inv_a    = t0_reg[TW-1] ? inv_u + {2'b00, m_reg} : inv_u;
        inv_b    = (inv_a >= {2'b00, m_reg}) ? inv_a - {2'b00, m_reg} : inv_a;
    end

    assign x3_part = subm(tmp_reg, rx_reg, m_reg);
    assign x3_next = subm(x3_part, sx_reg, m_reg);

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cfg_reg    <= '0;
            m_reg        <= M_RST;
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_CURVE_A:       a_cfg_reg <= cfg_wdata;
                    CFG_PRIME_MODULUS: m_reg     <= cfg_wdata;
                    default:           a_cfg_reg <= a_cfg_reg;
                endcase
            end
            if (cmd.op == OP_MUL)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= CW'(F);
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg - CW'(1);
                if (mul_done)
                begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (cmd.op == OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= CW'(F);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - CW'(1);
                if (div_done)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        // Advance the multiplier and write its result
        if (mul_busy_reg)
        begin
            mul_acc_reg <= mul_res;
            mul_u_reg   <= {mul_u_reg[F-2:0], 1'b0};
            if (mul_done)
            begin
                case (mul_dst_reg)
                    DST_A:   a_reg   <= mul_res;
                    DST_P1X: p1x_reg <= mul_res;
                    DST_P1Y: p1y_reg <= mul_res;
                    DST_SX:  sx_reg  <= mul_res;
                    DST_SY:  sy_reg  <= mul_res;
                    DST_TMP: tmp_reg <= mul_res;
                    DST_LAM: lam_reg <= mul_res;
                    default: tmp_reg <= mul_res;
                endcase
            end
        end
        // Advance the divider
        if (div_busy_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                req_reg   <= req_type;
                p1x_reg   <= first_x;
                p1y_reg   <= first_y;
                p1inf_reg <= first_inf;
                sx_reg    <= second_x;
                sy_reg    <= second_y;
                sinf_reg  <= second_inf;
                k_reg     <= scalar;
            end
            OP_MUL:
            begin
                mul_u_reg   <= mul_u_src;
                mul_v_reg   <= mul_v_src;
                mul_acc_reg <= '0;
                mul_dst_reg <= cmd.dst;
            end
            OP_R_FROM_P1:
            begin
                rx_reg   <= p1x_reg;
                ry_reg   <= p1y_reg;
                rinf_reg <= p1inf_reg;
            end
            OP_R_FROM_S:
            begin
                rx_reg   <= sx_reg;
                ry_reg   <= sy_reg;
                rinf_reg <= sinf_reg;
            end
            OP_S_FROM_R:
            begin
                sx_reg   <= rx_reg;
                sy_reg   <= ry_reg;
                sinf_reg <= rinf_reg;
            end
            OP_S_FROM_P1:
            begin
                sx_reg   <= p1x_reg;
                sy_reg   <= p1y_reg;
                sinf_reg <= p1inf_reg;
            end
            OP_SET_INF:
            begin
                rx_reg   <= '0;
                ry_reg   <= '0;
                rinf_reg <= 1'b1;
            end
            OP_NUM_DBL:
            begin
                num_reg <= addm(tmp_reg, a_reg, m_reg);
                den_reg <= addm(ry_reg, ry_reg, m_reg);
            end
            OP_NUM_CHORD:
            begin
                num_reg <= subm(sy_reg, ry_reg, m_reg);
                den_reg <= subm(sx_reg, rx_reg, m_reg);
            end
            OP_INV_INIT:
            begin
                r0_reg <= m_reg;
                r1_reg <= den_reg;
                t0_reg <= '0;
                t1_reg <= TW'(1);
            end
            OP_DIV:
            begin
                div_q_reg   <= r0_reg;
                div_rem_reg <= '0;
            end
            OP_EUC_STEP:
            begin
                r0_reg <= r1_reg;
                r1_reg <= div_rem_reg;
                t0_reg <= t1_reg;
                t1_reg <= euc_tn[TW-1:0];
            end
            OP_INV_FIN:
            begin
                tmp_reg <= inv_b[F-1:0];
            end
            OP_X3:
            begin
                x3_reg <= x3_next;
            end
            OP_DIFF:
            begin
                tmp_reg <= subm(rx_reg, x3_reg, m_reg);
            end
            OP_Y3:
            begin
                rx_reg   <= x3_reg;
                ry_reg   <= subm(tmp_reg, ry_reg, m_reg);
                rinf_reg <= 1'b0;
            end
            OP_KSHIFT:
            begin
                k_reg <= {k_reg[S-2:0], 1'b0};
            end
            default:
            begin
                x3_reg <= x3_reg;
            end
        endcase
    end

    // Status toward the sequencer
    always_comb
    begin
        status.mul_done  = mul_done;
        status.div_done  = div_done;
        status.small_mod = (m_reg < F'(3));
        status.req_mul   = (req_reg == REQ_MUL);
        status.rinf      = rinf_reg;
        status.sinf      = sinf_reg;
        status.p1inf     = p1inf_reg;
        status.xeq       = (rx_reg == sx_reg);
        status.yeq       = (ry_reg == sy_reg);
        status.yneg      = (addm(ry_reg, sy_reg, m_reg) == '0);
        status.r1zero    = (r1_reg == '0);
        status.gcd_one   = (r0_reg == F'(1));
        status.kbit      = k_reg[S-1];
        status.kzero     = (k_reg == '0);
    end

    // Present the accumulated point, zero coordinates at infinity
    assign result_x   = rinf_reg ? '0 : rx_reg;
    assign result_y   = rinf_reg ? '0 : ry_reg;
    assign result_inf = rinf_reg;

endmodule
`default_nettype wire

// ===== rtl/ec_point_add_and_scalar_multiply.sv =====
// Top level of the elliptic curve point add and scalar multiply block
//
//  channel   direction  payload (lowest bit first)
//  s_axis    in         tdata: first_x, first_y, first_inf, second_x, second_y,
//                       second_inf, scalar; tuser: req_type
//  m_axis    out        tdata: result_x, result_y, result_inf
//  cfg       in         cfg_addr 0 = curve_a, 1 = prime_modulus
//
// One request at a time. A modular product runs through the serial multiplier, and
// each Euclid step through the serial divider. A point addition takes up to five
// modular products and E Euclid steps (E up to about 1.5*F); a scalar multiply runs
// up to 2*S point additions, an add request one, plus five products to reduce.
// Reset clears configuration to a = 0, p = 65521 and empties the output register.
// The next request is taken while a finished result waits on m_axis.
`default_nettype none
`include "ec_point_add_and_scalar_multiply_defines.svh"
module ec_point_add_and_scalar_multiply
    import ecpm_pkg::*;
#(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 16,
    localparam int IN_W  = 4 * FIELD_BITS + 2 + SCALAR_BITS,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 2 * FIELD_BITS + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [FIELD_BITS-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // first_x, first_y, first_inf, second_x, second_y, second_inf, scalar
    input  wire logic [IN_TW-1:0]      s_axis_tdata,
    // req_type
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // result_x, result_y, result_inf
    output logic [OUT_TW-1:0]          m_axis_tdata
);

    localparam int F = FIELD_BITS;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               out_load, out_free;
    logic [F-1:0]       res_x, res_y;
    logic               res_inf;
    logic               m_tvalid_reg;
    logic [OUT_TW-1:0]  m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_axis_tready;

    ecpm_ctrl #(
        .SCALAR_BITS(SCALAR_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    ecpm_datapath #(
        .FIELD_BITS (FIELD_BITS),
        .SCALAR_BITS(SCALAR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req_type   (s_axis_tuser),
        .first_x    (s_axis_tdata[F-1:0]),
        .first_y    (s_axis_tdata[2*F-1:F]),
        .first_inf  (s_axis_tdata[2*F]),
        .second_x   (s_axis_tdata[3*F:2*F+1]),
        .second_y   (s_axis_tdata[4*F:3*F+1]),
        .second_inf (s_axis_tdata[4*F+1]),
        .scalar     (s_axis_tdata[IN_W-1:4*F+2]),
        .cmd        (cmd),
        .status     (status),
        .result_x   (res_x),
        .result_y   (res_y),
        .result_inf (res_inf)
    );

    // Output register: load a finished transaction, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= OUT_TW'({res_inf, res_y, res_x});
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Checks on the sequencing
    `ECPM_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_load, !m_tvalid_reg || m_axis_tready)
    `ECPM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ECPM_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, m_axis_tvalid)
    `ECPM_ASSERT_NOW(a_inf_zero, clk, rst_n, m_tvalid_reg && m_tdata_reg[2*F], m_tdata_reg[2*F-1:0] == '0)

endmodule
`default_nettype wire
